### design/mqd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mqd_pkg
// Shared types, widths and the phase transition table used by the
// multichannel quadrature decoder.
// ----------------------------------------------------------------------------
package mqd_pkg;

  localparam int CHANNELS = 16;
  localparam int CH_W     = 4;
  localparam int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PULSE_W  = 4;
  localparam int COUNT_W  = 8;
  localparam int DELTA_W  = 3;

  typedef logic [1:0]                 phase_t;
  typedef logic signed [COUNT_W-1:0]  count_t;
  typedef logic signed [DELTA_W-1:0]  delta_t;
  typedef logic [CH_W-1:0]            chan_t;
  typedef logic [PULSE_W-1:0]         pulses_t;
  typedef logic [IDX_W-1:0]           idx_t;

  // Per-channel decoder state.
  typedef struct packed {
    phase_t phase;
    count_t count;
  } mqd_state_t;

  // One accepted sample as held in the input register.
  typedef struct packed {
    chan_t   channel;
    logic    phase_a;
    logic    phase_b;
    pulses_t pulses;
  } mqd_sample_t;

  // Count change indexed by {old pair, new pair}. Opposite corners count two.
  localparam delta_t DELTA_TABLE [16] = '{
     3'sd0,  3'sd1, -3'sd1,  3'sd2,
    -3'sd1,  3'sd0, -3'sd2,  3'sd1,
     3'sd1, -3'sd2,  3'sd0, -3'sd1,
     3'sd2, -3'sd1,  3'sd1,  3'sd0
  };

endpackage
`default_nettype wire

### design/mqd_stream_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mqd_sample_if / mqd_result_if
// Valid/ready channels carrying encoder samples in and step results out.
// ----------------------------------------------------------------------------
interface mqd_sample_if;
  logic       valid;
  logic       ready;
  logic [3:0] channel;
  logic       phase_a;
  logic       phase_b;
  logic [3:0] pulses_per_detent;

  modport source (output valid, channel, phase_a, phase_b, pulses_per_detent,
                  input ready);
  modport sink   (input valid, channel, phase_a, phase_b, pulses_per_detent,
                  output ready);
endinterface

interface mqd_result_if;
  logic       valid;
  logic       ready;
  logic [3:0] channel_out;
  logic       step_up;
  logic       step_down;

  modport source (output valid, channel_out, step_up, step_down, input ready);
  modport sink   (input valid, channel_out, step_up, step_down, output ready);
endinterface
`default_nettype wire

### design/mqd_state.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mqd_state
// Per-channel phase and position storage, one read and one write port.
// ----------------------------------------------------------------------------
module mqd_state import mqd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire idx_t       rd_idx,
  output mqd_state_t      rd_data,
  input  wire logic       wr_en,
  input  wire idx_t       wr_idx,
  input  wire mqd_state_t wr_data
);

  mqd_state_t store [CHANNELS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        store[i] <= '0;
      end
    end else if (wr_en) begin
      store[wr_idx] <= wr_data;
    end
  end

  assign rd_data = store[rd_idx];

endmodule
`default_nettype wire

### design/mqd_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mqd_step
// Applies one phase transition to a channel's count and detects detent steps.
// ----------------------------------------------------------------------------
module mqd_step import mqd_pkg::*; (
  input  wire mqd_state_t cur,
  input  wire phase_t     now,
  input  wire pulses_t    pulses,
  output mqd_state_t      nxt,
  output logic            up,
  output logic            down
);

  delta_t                    delta;
  count_t                    pulses_ext;
  count_t                    sum;
  count_t                    after_up;
  logic signed [COUNT_W:0]   pulses_w;

  always_comb begin
    delta      = DELTA_TABLE[{cur.phase, now}];
    pulses_ext = count_t'({{(COUNT_W-PULSE_W){1'b0}}, pulses});
    pulses_w   = (COUNT_W+1)'(pulses_ext);
    sum        = cur.count + COUNT_W'(delta);

    // Compare one bit wider so that negating the threshold cannot wrap.
    up       = ((COUNT_W+1)'(sum) >= pulses_w);
    after_up = up ? (sum - pulses_ext) : sum;

    down      = ((COUNT_W+1)'(after_up) <= -pulses_w);
    nxt.count = down ? (after_up + pulses_ext) : after_up;
    nxt.phase = now;
  end

endmodule
`default_nettype wire

### design/multichannel_quadrature_decoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_quadrature_decoder_unit
// Quadrature decoder for many encoders with per-channel detent counting.
// ----------------------------------------------------------------------------
// Usage:
//   samples carries one encoder sample per transfer: channel number, the two
//   phase levels and the pulses per detent for that channel. results returns
//   exactly one item per sample, in order: the channel and the step_up and
//   step_down flags for that sample.
//   A sample transfer loads the input register, where the channel state is
//   read, updated and written back while the result register loads.
//   Throughput is one sample per cycle while results is not stalled,
//   including back-to-back samples of the same channel, since each update
//   is written before the next sample reads the state.
//   A synchronous reset clears both pipeline stages and sets every channel's
//   phase pair and position count to zero.
//   When results is stalled, the held result stays put and one more sample
//   can still be taken into the input register; samples.ready drops only
//   when both stages are full.
// ----------------------------------------------------------------------------
module multichannel_quadrature_decoder_unit import mqd_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  mqd_sample_if.sink   samples,
  mqd_result_if.source results
);

  logic        s1_valid;
  mqd_sample_t s1;
  logic        res_valid;
  chan_t       res_channel;
  logic        res_up;
  logic        res_down;

  logic        advance;
  logic        take;
  logic        ch_ok;
  idx_t        idx;
  mqd_state_t  cur_state;
  mqd_state_t  nxt_state;
  logic        up;
  logic        down;

  assign advance       = s1_valid && (!res_valid || results.ready);
  assign samples.ready = !s1_valid || advance;
  assign take          = samples.valid && samples.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1.channel <= samples.channel;
      s1.phase_a <= samples.phase_a;
      s1.phase_b <= samples.phase_b;
      s1.pulses  <= samples.pulses_per_detent;
    end
  end

  assign ch_ok = (int'(s1.channel) < CHANNELS);
  assign idx   = IDX_W'(s1.channel);

  mqd_state u_state (
    .clk     (clk),
    .rst     (rst),
    .rd_idx  (idx),
    .rd_data (cur_state),
    .wr_en   (advance && ch_ok),
    .wr_idx  (idx),
    .wr_data (nxt_state)
  );

  mqd_step u_step (
    .cur    (cur_state),
    .now    ({s1.phase_b, s1.phase_a}),
    .pulses (s1.pulses),
    .nxt    (nxt_state),
    .up     (up),
    .down   (down)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (results.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_channel <= s1.channel;
      res_up      <= up && ch_ok;
      res_down    <= down && ch_ok;
    end
  end

  assign results.valid       = res_valid;
  assign results.channel_out = res_channel;
  assign results.step_up     = res_up;
  assign results.step_down   = res_down;

  // With a nonzero threshold, a count reduced after an upward step can never
  // also reach the downward threshold.
  a_no_double_step: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1.pulses != '0) |-> !(up && down))
    else $error("both step flags set with a nonzero threshold");

  // An empty input register must always be able to take a sample.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> samples.ready)
    else $error("sample channel stalled with an empty input register");

  // A result appears only for a sample that moved out of the input register.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(s1_valid))
    else $error("result produced without a pending sample");

endmodule
`default_nettype wire

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Multichannel quadrature decoder testbench
// Drives encoder samples through the valid/ready sample channel and checks
// every step result against a per-channel decoder model kept in the bench.
// Directed samples cover each kind of phase transition, the extreme
// channels and thresholds, and a zero threshold. Random Gray-code walks
// follow, with noise and long spins that wrap the position count. The
// sender idles and the receiver stalls at several rates.
// ----------------------------------------------------------------------------
module tb;
  import mqd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    chan_t channel;
    logic  step_up;
    logic  step_down;
  } step_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mqd_sample_if samples_ch ();
  mqd_result_if results_ch ();

  multichannel_quadrature_decoder_unit dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_ch),
    .results (results_ch)
  );

  // Bench-side drive registers, known from time zero.
  logic        sample_valid = 1'b0;
  mqd_sample_t sample_item  = '0;
  logic        result_ready = 1'b0;

  assign samples_ch.valid             = sample_valid;
  assign samples_ch.channel           = sample_item.channel;
  assign samples_ch.phase_a           = sample_item.phase_a;
  assign samples_ch.phase_b           = sample_item.phase_b;
  assign samples_ch.pulses_per_detent = sample_item.pulses;
  assign results_ch.ready             = result_ready;

  mqd_sample_t  pending_samples [$];
  step_result_t expected_steps [$];
  int           queued_count   = 0;
  int           accepted_count = 0;
  int           mismatch_count = 0;
  int           send_idle_pct  = 0;
  int           stall_pct      = 0;

  // Decoder model state per channel.
  phase_t phase_mem [CHANNELS];
  count_t count_mem [CHANNELS];

  // Stimulus generator state per channel.
  phase_t  gen_phase  [16];
  bit      gen_dir    [16];
  pulses_t gen_pulses [16];
  int      gen_chan   = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Next pair of a Gray-code walk; upward runs 00, 01, 11, 10.
  function automatic phase_t gray_next(phase_t p, bit up);
    case (p)
      2'b00:   return up ? 2'b01 : 2'b10;
      2'b01:   return up ? 2'b11 : 2'b00;
      2'b11:   return up ? 2'b10 : 2'b01;
      default: return up ? 2'b00 : 2'b11;
    endcase
  endfunction

  function automatic int phase_delta(phase_t prev, phase_t now);
    if (prev == now) return 0;
    if (gray_next(prev, 1'b1) == now) return 1;
    if (gray_next(prev, 1'b0) == now) return -1;
    // Opposite corners: 00 and 11 swap upward, 01 and 10 swap downward.
    if (prev == 2'b00 || prev == 2'b11) return 2;
    return -2;
  endfunction

  function automatic step_result_t decode_sample(mqd_sample_t s);
    step_result_t r;
    phase_t       now;
    count_t       c;
    int           ci;
    int           p;
    r.channel   = s.channel;
    r.step_up   = 1'b0;
    r.step_down = 1'b0;
    if (int'(s.channel) < CHANNELS) begin
      now = {s.phase_b, s.phase_a};
      p   = int'(s.pulses);
      c   = count_mem[s.channel] + count_t'(phase_delta(phase_mem[s.channel], now));
      ci  = int'(c);
      if (ci >= p) begin
        r.step_up = 1'b1;
        c = c - count_t'(p);
      end
      ci = int'(c);
      if (ci <= -p) begin
        r.step_down = 1'b1;
        c = c + count_t'(p);
      end
      phase_mem[s.channel] = now;
      count_mem[s.channel] = c;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 50) $display("%0t ns: %s", $time, what);
  endtask

  task automatic push_sample(int ch, bit a, bit b, int p);
    mqd_sample_t s;
    s.channel = chan_t'(ch);
    s.phase_a = a;
    s.phase_b = b;
    s.pulses  = pulses_t'(p);
    gen_phase[ch] = {b, a};
    pending_samples.push_back(s);
    queued_count++;
  endtask

  task automatic pick_thresholds();
    for (int i = 0; i < 16; i++) begin
      case ($urandom_range(3))
        0:       gen_pulses[i] = 1;
        1:       gen_pulses[i] = 2;
        2:       gen_pulses[i] = 4;
        default: gen_pulses[i] = pulses_t'($urandom_range(15, 1));
      endcase
    end
  endtask

  // Mostly Gray-code walks that stay on one channel for a while; the rest is
  // random phase noise, direction reversals and an odd threshold.
  task automatic push_random_sample();
    phase_t nxt;
    int     p;
    int     roll;
    if ($urandom_range(99) < 20) gen_chan = $urandom_range(15);
    roll = $urandom_range(99);
    if (roll < 10) gen_dir[gen_chan] = ~gen_dir[gen_chan];
    if (roll < 85) nxt = gray_next(gen_phase[gen_chan], gen_dir[gen_chan]);
    else nxt = phase_t'($urandom_range(3));
    if ($urandom_range(99) < 3) p = $urandom_range(15);
    else p = gen_pulses[gen_chan];
    push_sample(gen_chan, nxt[0], nxt[1], p);
  endtask

  // A zero threshold never reduces the count, so a long spin wraps it.
  task automatic push_spin(int ch, bit up, int n);
    phase_t nxt;
    for (int i = 0; i < n; i++) begin
      if (up) nxt = (gen_phase[ch] == 2'b11) ? 2'b00 : 2'b11;
      else    nxt = (gen_phase[ch] == 2'b01) ? 2'b10 : 2'b01;
      push_sample(ch, nxt[0], nxt[1], 0);
    end
  endtask

  task automatic wait_accepted();
    while (accepted_count != queued_count) @(posedge clk);
  endtask

  task automatic wait_drained();
    wait_accepted();
    while (expected_steps.size() != 0) @(posedge clk);
  endtask

  // Driver: a new sample is presented once the previous one has transferred.
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && samples_ch.ready) begin
        expected_steps.push_back(decode_sample(sample_item));
        accepted_count++;
      end
      if (!sample_valid || samples_ch.ready) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          sample_item  <= pending_samples.pop_front();
          sample_valid <= 1'b1;
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: each result transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    step_result_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (results_ch.valid && result_ready) begin
        if (expected_steps.size() == 0) begin
          report_mismatch($sformatf("result for channel %0d with none expected",
                                    results_ch.channel_out));
        end else begin
          want = expected_steps.pop_front();
          if (results_ch.channel_out !== want.channel)
            report_mismatch($sformatf("channel_out got %0d expected %0d",
                                      results_ch.channel_out, want.channel));
          if (results_ch.step_up !== want.step_up)
            report_mismatch($sformatf("channel %0d step_up got %b expected %b",
                                      want.channel, results_ch.step_up, want.step_up));
          if (results_ch.step_down !== want.step_down)
            report_mismatch($sformatf("channel %0d step_down got %b expected %b",
                                      want.channel, results_ch.step_down,
                                      want.step_down));
        end
      end
      result_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    for (int i = 0; i < CHANNELS; i++) begin
      phase_mem[i] = '0;
      count_mem[i] = '0;
    end
    for (int i = 0; i < 16; i++) begin
      gen_phase[i] = '0;
      gen_dir[i]   = 1'b1;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: single steps both ways, opposite corners, extremes.
    send_idle_pct = 0;
    stall_pct     = 0;
    push_sample(0, 1, 0, 1);
    push_sample(0, 1, 1, 1);
    push_sample(0, 0, 1, 1);
    push_sample(0, 0, 0, 1);
    push_sample(0, 0, 1, 1);
    push_sample(0, 1, 1, 1);
    push_sample(0, 1, 0, 1);
    push_sample(0, 0, 0, 1);
    push_sample(15, 1, 1, 15);
    push_sample(15, 0, 0, 15);
    push_sample(15, 1, 0, 15);
    push_sample(15, 0, 1, 15);
    push_sample(15, 1, 0, 15);
    push_sample(15, 1, 0, 15);
    // Zero threshold: a count of zero flags both directions.
    push_sample(7, 0, 0, 0);
    push_sample(7, 1, 1, 0);
    push_sample(7, 0, 0, 0);
    push_sample(7, 0, 1, 0);
    push_sample(7, 1, 0, 0);
    push_sample(7, 0, 1, 0);
    push_sample(7, 1, 0, 0);
    push_sample(8, 1, 1, 2);
    push_sample(8, 0, 0, 2);
    push_sample(8, 1, 0, 15);
    wait_accepted();

    pick_thresholds();
    repeat (220) push_random_sample();
    wait_accepted();

    send_idle_pct = 64;
    stall_pct     = 0;
    pick_thresholds();
    push_spin(9, 1'b1, 70);
    push_spin(10, 1'b0, 70);
    repeat (220) push_random_sample();
    // Hold the sender until every outstanding result has come back.
    wait_drained();
    repeat (60) push_random_sample();

    wait_accepted();
    send_idle_pct = 0;
    stall_pct     = 64;
    pick_thresholds();
    repeat (220) push_random_sample();
    wait_accepted();

    send_idle_pct = 22;
    stall_pct     = 22;
    pick_thresholds();
    repeat (220) push_random_sample();

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_steps.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
